// File: hdl/oaiht_pkg.sv
package oaiht_pkg;

  localparam int REQ_W        = 3;
  localparam int KEY_W        = 64;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 3;
  localparam int LIVE_COUNT_W = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET     = 3'd0,
    REQ_SET     = 3'd1,
    REQ_SET_NEW = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_NOT_FOUND = 3'd0,
    RS_FOUND     = 3'd1,
    RS_INSERTED  = 3'd2,
    RS_EXISTS    = 3'd3,
    RS_FULL      = 3'd4
  } resp_status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_APPLY
  } state_t;

endpackage

// File: hdl/open_address_int_hash_table_top.sv
// Open-addressed hash table with 64-bit integer keys (the key is its own hash) and
// perturbation probing. Requests are get, set, set-if-absent, remove and clear; each
// returns one result. One request is worked on at a time: the request is taken, then
// every slot probed takes a synchronous read of the slot memories and then a key compare
// and next-index computation, and last the result is written back and presented, which
// waits while an earlier result is still held on the output. A probe visits at most
// TABLE_DEPTH+65 slots. After reset, and on every clear request, the slot-state memory
// is swept one entry per cycle, during which no request is taken; a clear returns its
// result after the sweep. A new request may be taken while the previous result is still
// waiting on the output.
module open_address_int_hash_table_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PROBE_SHIFT = 5,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oaiht_pkg::REQ_W-1:0]         in_req_type,
  input  logic [oaiht_pkg::KEY_W-1:0]         in_key,
  input  logic [oaiht_pkg::VALUE_W-1:0]       in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oaiht_pkg::STATUS_W-1:0]      out_status,
  output logic [oaiht_pkg::VALUE_W-1:0]       out_value_out,
  output logic [oaiht_pkg::LIVE_COUNT_W-1:0]  out_live_count
);

  import oaiht_pkg::*;

  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PROBE_LIMIT = 64 + TABLE_DEPTH;
  localparam int N_W         = $clog2(PROBE_LIMIT + 1);
  localparam int KV_W        = KEY_W + VALUE_BITS;
  localparam logic [CNT_W+1:0] FULL_LIM = (CNT_W+2)'((TABLE_DEPTH - 1) * 2);
  localparam logic [CNT_W+1:0] USED_CAP = (CNT_W+2)'((TABLE_DEPTH - 1) * 2 + 3);

  // slot memories
  logic [KV_W-1:0] kv_mem [TABLE_DEPTH];
  slot_t           st_mem [TABLE_DEPTH];

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]      req_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]      idx_r;
  logic [KEY_W-1:0]      perturb_r;
  logic [N_W-1:0]        n_r;
  logic [IDX_W-1:0]      spare_r;
  logic                  spare_v_r;
  logic [IDX_W-1:0]      fin_slot_r;
  slot_t                 fin_stat_r;
  logic                  fin_ok_r;
  logic [VALUE_BITS-1:0] fin_val_r;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic                  clr_req_r;

  logic [KV_W-1:0] kv_rd_r;
  slot_t           st_rd_r;

  logic                 out_valid_r;
  resp_status_t         out_status_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [LIVE_COUNT_W-1:0] out_live_r;

  // probe evaluation
  logic            ev_empty, ev_match, ev_last, probe_done;
  logic            spare_v_new;
  logic [IDX_W-1:0] spare_new;
  logic [IDX_W-1:0] idx_next;

  // apply
  logic            in_fire, apply_fire, clr_last;
  resp_status_t    res_status;
  logic [VALUE_W-1:0] res_value;
  logic            kv_we, st_we;
  logic [IDX_W-1:0] st_waddr;
  slot_t           st_wdata;
  logic [CNT_W+1:0] used_x3;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_ready);
  assign clr_last   = (clr_cnt_r == {IDX_W{1'b1}});

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_live_count = out_live_r;

  assign used_x3 = ((CNT_W+2)'(used_r) << 1) + (CNT_W+2)'(used_r);

  always_comb begin
    ev_empty    = (st_rd_r == SLOT_EMPTY);
    ev_match    = (kv_rd_r[KV_W-1 -: KEY_W] == key_r);
    ev_last     = (n_r == N_W'(PROBE_LIMIT));
    probe_done  = ev_empty || ev_match || ev_last;
    spare_v_new = spare_v_r || (st_rd_r == SLOT_TOMB);
    spare_new   = spare_v_r ? spare_r : idx_r;
    // only the low index bits of i and perturb reach the next index
    idx_next    = ((idx_r << 2) + idx_r) + perturb_r[IDX_W-1:0] + IDX_W'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_req_r ? S_APPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_GET, REQ_SET, REQ_SET_NEW, REQ_REMOVE: state_nxt = S_READ;
            REQ_CLEAR:                                 state_nxt = S_CLEAR;
            default:                                   state_nxt = S_APPLY;
          endcase
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: state_nxt = probe_done ? S_APPLY : S_READ;
      S_APPLY: begin
        if (apply_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // result and write-back decode
  always_comb begin
    res_status = RS_NOT_FOUND;
    res_value  = '0;
    kv_we      = 1'b0;
    st_we      = 1'b0;
    st_waddr   = fin_slot_r;
    st_wdata   = SLOT_LIVE;
    used_nxt   = used_r;
    live_nxt   = live_r;
    if (state_r == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_r;
      st_wdata = SLOT_EMPTY;
    end else if (apply_fire) begin
      unique case (req_r)
        REQ_GET, REQ_REMOVE: begin
          if (fin_ok_r && fin_stat_r == SLOT_LIVE) begin
            res_status = RS_FOUND;
            res_value  = VALUE_W'(fin_val_r);
            if (req_r == REQ_REMOVE) begin
              st_we    = 1'b1;
              st_wdata = SLOT_TOMB;
              live_nxt = live_r - CNT_W'(1);
            end
          end
        end
        REQ_SET, REQ_SET_NEW: begin
          if (!fin_ok_r) begin
            res_status = RS_FULL;
          end else if (fin_stat_r == SLOT_LIVE) begin
            if (req_r == REQ_SET) begin
              kv_we      = 1'b1;
              res_status = RS_FOUND;
            end else begin
              res_status = RS_EXISTS;
            end
          end else if (fin_stat_r == SLOT_EMPTY && used_x3 > FULL_LIM) begin
            res_status = RS_FULL;
          end else begin
            kv_we      = 1'b1;
            st_we      = 1'b1;
            st_wdata   = SLOT_LIVE;
            live_nxt   = live_r + CNT_W'(1);
            if (fin_stat_r == SLOT_EMPTY) begin
              used_nxt = used_r + CNT_W'(1);
            end
            res_status = RS_INSERTED;
          end
        end
        REQ_CLEAR: res_status = RS_FOUND;
        default:   res_status = RS_NOT_FOUND;
      endcase
    end
  end

  // memories: requests are serialized, so a write-back never overlaps a read
  always_ff @(posedge clk) begin
    if (kv_we) begin
      kv_mem[fin_slot_r] <= {key_r, val_r};
    end
    if (state_r == S_READ) begin
      kv_rd_r <= kv_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (state_r == S_READ) begin
      st_rd_r <= st_mem[idx_r];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_req_r   <= 1'b0;
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (in_fire) begin
        clr_req_r <= (in_req_type == REQ_CLEAR);
        if (in_req_type == REQ_CLEAR) begin
          used_r <= '0;
          live_r <= '0;
        end
      end else if (apply_fire) begin
        used_r <= used_nxt;
        live_r <= live_nxt;
      end
      if (apply_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r     <= in_req_type;
      key_r     <= in_key;
      val_r     <= VALUE_BITS'(in_value);
      idx_r     <= in_key[IDX_W-1:0];
      perturb_r <= in_key;
      n_r       <= '0;
      spare_v_r <= 1'b0;
      spare_r   <= '0;
    end
    if (state_r == S_EVAL) begin
      if (ev_empty) begin
        fin_ok_r   <= 1'b1;
        fin_slot_r <= spare_v_r ? spare_r : idx_r;
        fin_stat_r <= spare_v_r ? SLOT_TOMB : SLOT_EMPTY;
      end else if (ev_match) begin
        fin_ok_r   <= 1'b1;
        fin_slot_r <= idx_r;
        fin_stat_r <= st_rd_r;
        fin_val_r  <= kv_rd_r[VALUE_BITS-1:0];
      end else begin
        spare_v_r <= spare_v_new;
        spare_r   <= spare_new;
        if (ev_last) begin
          // limit hit: fall back to the first tombstone, if any
          fin_ok_r   <= spare_v_new;
          fin_slot_r <= spare_new;
          fin_stat_r <= SLOT_TOMB;
        end else begin
          idx_r     <= idx_next;
          perturb_r <= perturb_r >> PROBE_SHIFT;
          n_r       <= n_r + N_W'(1);
        end
      end
    end
    if (apply_fire) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_live_r   <= LIVE_COUNT_W'(live_nxt);
    end
  end

  a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= used_r)
    else $error("live count exceeds used slot count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_x3 <= USED_CAP)
    else $error("used slots passed the fill bound");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_fire && res_status == RS_INSERTED) |=> live_r == $past(live_r) + CNT_W'(1))
    else $error("insert did not bump live count");

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(state_r) == S_READ)
    else $error("slot compare without a memory read");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import oaiht_pkg::*;

  localparam int          DEPTH       = 1024;
  localparam int          PERT_SHIFT  = 5;
  localparam logic [63:0] IDX_MASK    = 64'(DEPTH - 1);
  localparam int          PROBE_STEPS = 64 + DEPTH;
  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          TAIL_CYCLES = 100;
  localparam int          FILL_TARGET = 720;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;

  typedef struct {
    logic [REQ_W-1:0]   op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] val;
    bit                 drain;
  } table_req_t;

  typedef struct {
    resp_status_t            status;
    logic [VALUE_W-1:0]      value;
    logic [LIVE_COUNT_W-1:0] live;
  } table_resp_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic [KEY_W-1:0]        in_key = '0;
  logic [VALUE_W-1:0]      in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [VALUE_W-1:0]      out_value_out;
  logic [LIVE_COUNT_W-1:0] out_live_count;

  open_address_int_hash_table_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_live_count (out_live_count)
  );

  // shadow copy of the table
  logic [KEY_W-1:0]   slot_key   [DEPTH];
  logic [VALUE_W-1:0] slot_val   [DEPTH];
  slot_t              slot_state [DEPTH];
  int                 used_cnt = 0;
  int                 live_cnt = 0;

  table_req_t  req_q[$];
  table_resp_t table_resp_q[$];
  int          n_items = 0;
  int          accepted_cnt = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycle_cnt = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_state[i] = SLOT_EMPTY;
  end

  // walk the probe sequence; 0 only when the step limit runs out with no tombstone
  function automatic bit probe_slot(input logic [KEY_W-1:0] k, output int unsigned slot);
    logic [63:0] pos;
    logic [63:0] pert;
    int unsigned idx;
    int unsigned spare;
    bit          have;
    int          n;
    pos   = k;
    pert  = k;
    idx   = int'(k & IDX_MASK);
    spare = 0;
    have  = 1'b0;
    slot  = 0;
    if (slot_state[idx] == SLOT_EMPTY || slot_key[idx] == k) begin
      slot = idx;
      return 1'b1;
    end
    if (slot_state[idx] == SLOT_TOMB) begin
      spare = idx;
      have  = 1'b1;
    end
    for (n = 0; n < PROBE_STEPS; n++) begin
      pos = pos * 64'd5 + pert + 64'd1;
      idx = int'(pos & IDX_MASK);
      if (slot_state[idx] == SLOT_EMPTY) begin
        slot = have ? spare : idx;
        return 1'b1;
      end
      if (slot_key[idx] == k) begin
        slot = idx;
        return 1'b1;
      end
      if (slot_state[idx] == SLOT_TOMB && !have) begin
        spare = idx;
        have  = 1'b1;
      end
      pert = pert >> PERT_SHIFT;
    end
    slot = spare;
    return have;
  endfunction

  function automatic void hash_apply(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                                     input logic [VALUE_W-1:0] v);
    table_resp_t r;
    int unsigned s;
    bit          ok;
    r.status = RS_NOT_FOUND;
    r.value  = '0;
    case (op)
      REQ_GET, REQ_REMOVE: begin
        ok = probe_slot(k, s);
        if (ok && slot_state[s] == SLOT_LIVE) begin
          r.status = RS_FOUND;
          r.value  = slot_val[s];
          if (op == REQ_REMOVE) begin
            slot_state[s] = SLOT_TOMB;
            slot_val[s]   = '0;
            live_cnt--;
          end
        end
      end
      REQ_SET, REQ_SET_NEW: begin
        ok = probe_slot(k, s);
        if (!ok) begin
          r.status = RS_FULL;
        end else if (slot_state[s] == SLOT_LIVE) begin
          if (op == REQ_SET) begin
            slot_val[s] = v;
            r.status    = RS_FOUND;
          end else begin
            r.status = RS_EXISTS;
          end
        end else if (slot_state[s] == SLOT_EMPTY && used_cnt * 3 > (DEPTH - 1) * 2) begin
          r.status = RS_FULL;
        end else begin
          if (slot_state[s] == SLOT_EMPTY) used_cnt++;
          live_cnt++;
          slot_state[s] = SLOT_LIVE;
          slot_key[s]   = k;
          slot_val[s]   = v;
          r.status      = RS_INSERTED;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) slot_state[i] = SLOT_EMPTY;
        used_cnt = 0;
        live_cnt = 0;
        r.status = RS_FOUND;
      end
      default: ;
    endcase
    r.live = LIVE_COUNT_W'(live_cnt);
    table_resp_q.push_back(r);
  endfunction

  // ---------------- stimulus ----------------

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VALUE_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                         input logic [VALUE_W-1:0] v, input bit drain = 1'b0);
    table_req_t t;
    t.op    = op;
    t.key   = k;
    t.val   = v;
    t.drain = drain;
    req_q.push_back(t);
    n_items++;
  endtask

  // small key pool with clustered home slots so probes collide and tombstones pile up
  task automatic mixed_phase(input int count);
    logic [KEY_W-1:0] pool[40];
    logic [KEY_W-1:0] k;
    int               r;
    for (int i = 0; i < 40; i++) begin
      pool[i] = rand_key();
      case ($urandom_range(0, 3))
        0: pool[i][9:0] = 10'($urandom_range(0, 5) * 3);
        1: pool[i][9:0] = 10'($urandom_range(0, 7));
        2: pool[i] = {32'($urandom_range(0, 3)), 22'h0, 10'($urandom_range(0, 2))};
        default: ;
      endcase
    end
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, 39)];
      if (r < 30)      add_req(REQ_GET, k, rand_val());
      else if (r < 55) add_req(REQ_SET, k, rand_val());
      else if (r < 75) add_req(REQ_SET_NEW, k, rand_val());
      else if (r < 93) add_req(REQ_REMOVE, k, rand_val());
      else if (r < 96) add_req(REQ_CLEAR, k, rand_val());
      else add_req(REQ_UNUSED_FIRST + 3'($urandom_range(0, 2)), k, rand_val());
    end
  endtask

  initial begin
    logic [KEY_W-1:0] fill_keys[$];
    logic [KEY_W-1:0] k;
    int               fresh;
    int               r;

    // directed
    add_req(REQ_GET,     64'h0, 32'h0);
    add_req(REQ_SET,     64'h0, 32'hFFFF_FFFF);
    add_req(REQ_GET,     64'h0, 32'h0);
    add_req(REQ_SET_NEW, 64'h0, 32'h1);
    add_req(REQ_SET,     64'h0, 32'h0);
    add_req(REQ_SET,     '1,    32'h1234_5678);
    add_req(REQ_SET,     64'h400, 32'hA5A5_A5A5);
    add_req(REQ_SET_NEW, 64'h800, 32'h5A5A_5A5A);
    add_req(REQ_REMOVE,  64'h0, 32'h0);
    add_req(REQ_GET,     64'h0, 32'h0);        // matching tombstone ends the probe
    add_req(REQ_GET,     64'h400, 32'h0);      // probe runs past a tombstone
    add_req(REQ_SET_NEW, 64'hC00, 32'h0BAD_F00D);  // first tombstone reused
    add_req(REQ_REMOVE,  64'h400, 32'h0);
    add_req(REQ_SET,     64'h400, 32'h7777_0000);  // matching tombstone reused
    add_req(REQ_REMOVE,  64'h55, 32'h0);
    add_req(REQ_UNUSED_FIRST,        rand_key(), rand_val());
    add_req(REQ_UNUSED_FIRST + 3'd1, rand_key(), rand_val());
    add_req(REQ_UNUSED_FIRST + 3'd2, '1, '1);
    add_req(REQ_GET,     '1, 32'h0);
    add_req(REQ_CLEAR,   64'h0, 32'h0);
    add_req(REQ_GET,     '1, 32'h0);
    add_req(REQ_REMOVE,  64'h800, 32'h0);

    mixed_phase(20);
    mixed_phase(20);

    // drive the table past its fill bound with fresh keys
    fresh = 0;
    add_req(REQ_CLEAR, 64'h0, 32'h0, 1'b1);
    while (fresh < FILL_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 97 || fill_keys.size() == 0) begin
        if (fill_keys.size() != 0 && $urandom_range(0, 19) == 0) begin
          add_req(REQ_SET, fill_keys[$urandom_range(0, fill_keys.size() - 1)], rand_val());
        end else begin
          k = rand_key();
          fill_keys.push_back(k);
          add_req($urandom_range(0, 1) ? REQ_SET : REQ_SET_NEW, k, rand_val());
          fresh++;
        end
      end else if (r < 98) begin
        add_req(REQ_GET, fill_keys[$urandom_range(0, fill_keys.size() - 1)], rand_val());
      end else if (r < 99) begin
        add_req(REQ_REMOVE, fill_keys[$urandom_range(0, fill_keys.size() - 1)], rand_val());
      end else begin
        add_req(REQ_GET, rand_key(), rand_val());
      end
    end
    // at the bound: a same-key tombstone is still reusable; new keys need a tombstone
    for (int i = 0; i < 10; i++) begin
      k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
      add_req(REQ_REMOVE, k, rand_val());
      add_req(REQ_SET_NEW, k, rand_val());
      add_req(REQ_SET, rand_key(), rand_val());
    end
    add_req(REQ_CLEAR, 64'h0, 32'h0, 1'b1);
    mixed_phase(10);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != n_items || results_seen != accepted_cnt) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (table_resp_q.size() != 0) begin
      $error("%0d responses never arrived", table_resp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS open_address_int_hash_table_top");
    end else begin
      $display("FAIL open_address_int_hash_table_top");
    end
    $finish;
  end

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL open_address_int_hash_table_top");
      $finish;
    end
  end

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bit took;
    table_req_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        hash_apply(in_req_type, in_key, in_value);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].drain && (took || results_seen != accepted_cnt))) begin
          t = req_q.pop_front();
          in_valid    <= 1'b1;
          in_req_type <= t.op;
          in_key      <= t.key;
          in_value    <= t.val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                         ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                                        $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int          stall_left = 0;
  int          rx_tick = 0;
  table_resp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (table_resp_q.size() == 0) begin
          $error("result transaction with no request outstanding");
          errors++;
        end else begin
          want = table_resp_q.pop_front();
          results_seen <= results_seen + 1;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_value_out !== want.value) begin
            $error("value_out: expected %0h, got %0h", want.value, out_value_out);
            errors++;
          end
          if (out_live_count !== want.live) begin
            $error("live_count: expected %0d, got %0d", want.live, out_live_count);
            errors++;
          end
        end
      end
      rx_tick++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_tick / 300) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(2, 24);
          end
          default: out_ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

endmodule
